[rtl/tensor_permute_index_generator_core_macros.svh]
// assertion macros for the permute index generator checker
`ifndef TENSOR_PERMUTE_INDEX_GENERATOR_CORE_MACROS_SVH
`define TENSOR_PERMUTE_INDEX_GENERATOR_CORE_MACROS_SVH

// a holds, then b holds in the same cycle
`define TPIG_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tpig check failed");

// a holds, then b holds later, after the delay given by n
`define TPIG_ASSERT_LATER(label, clk, rst, a, n, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) \
    else $error("tpig check failed");

`endif

[rtl/tpig_pkg.sv]
// ----------------------------------------------------------------------------
// tpig_pkg
// shared constants, stage type and field helper of the permute index generator
// ----------------------------------------------------------------------------
package tpig_pkg;

  localparam int MAX_AXES  = 6;
  localparam int IDX_W     = 20;
  localparam int FIELD_W   = 20;
  localparam int REG_W     = 60;
  localparam int CNT_W     = 3;
  localparam int ORDER_W   = 18;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = (IDX_W + DIV_BITS - 1) / DIV_BITS;
  localparam int AXIS_ST   = DIV_STEPS + 1;
  localparam int NST       = MAX_AXES * AXIS_ST;
  localparam int LATENCY   = NST + 1;

  localparam logic [2:0] REG_AXIS_COUNT = 3'd0;
  localparam logic [2:0] REG_AXIS_ORDER = 3'd1;
  localparam logic [2:0] REG_IN_STR_LO  = 3'd2;
  localparam logic [2:0] REG_IN_STR_HI  = 3'd3;
  localparam logic [2:0] REG_OUT_STR_LO = 3'd4;
  localparam logic [2:0] REG_OUT_STR_HI = 3'd5;
  localparam logic [2:0] REG_DIMS_LO    = 3'd6;
  localparam logic [2:0] REG_DIMS_HI    = 3'd7;

  typedef struct packed {
    logic             contig;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] rest;
    logic [IDX_W-1:0] rem;
    logic [IDX_W-1:0] quo;
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] dst;
  } tpig_stage_t;

  function automatic logic [FIELD_W-1:0] pick_field(input logic [REG_W-1:0] lo,
                                                    input logic [REG_W-1:0] hi,
                                                    input logic [2:0] ax);
    logic [2*REG_W-1:0] both;
    logic [FIELD_W-1:0] f;
    both = {hi, lo};
    f = '0;
    if (ax < 3'(MAX_AXES)) begin
      f = both[ax*FIELD_W +: FIELD_W];
    end
    return f;
  endfunction

endpackage

[rtl/tensor_permute_index_generator_core.sv]
// ----------------------------------------------------------------------------
// tensor_permute_index_generator_core
// source and destination index generator for an axis permutation copy
// ----------------------------------------------------------------------------
// channel   signals                                   transfer
// input     start busy out_position contiguous        start && !busy
// result    done source_index dest_index              done, one cycle
// config    cfg_valid cfg_ready cfg_index cfg_data    cfg_valid && cfg_ready
//
// one beat enters per cycle; busy stays low and cfg_ready stays high
// a result leaves after its beat has passed the entry register and one pipeline slot per axis stage:
// six axes, each five radix-16 divide stages and one multiply-accumulate stage
// rst clears the stage valid bits and loads the register reset values
// the result side has no stall, so the pipeline always advances
// ----------------------------------------------------------------------------
module tensor_permute_index_generator_core
  import tpig_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [IDX_W-1:0]   out_position,
  input  logic               contiguous,
  output logic               done,
  output logic [IDX_W-1:0]   source_index,
  output logic [IDX_W-1:0]   dest_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [REG_W-1:0]   cfg_data
);

  logic [CNT_W-1:0]   axis_count;
  logic [ORDER_W-1:0] axis_order;
  logic [REG_W-1:0]   in_str_lo, in_str_hi, out_str_lo, out_str_hi, dims_lo, dims_hi;
  logic [2:0]         n_axes;

  tpig_stage_t st  [0:NST];
  logic        vld [0:NST];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign n_axes    = (axis_count > 3'(MAX_AXES)) ? 3'(MAX_AXES) : axis_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_count <= 3'd1;
      axis_order <= '0;
      in_str_lo  <= '0;
      in_str_hi  <= '0;
      out_str_lo <= '0;
      out_str_hi <= '0;
      dims_lo    <= '0;
      dims_hi    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AXIS_COUNT: axis_count <= cfg_data[CNT_W-1:0];
        REG_AXIS_ORDER: axis_order <= cfg_data[ORDER_W-1:0];
        REG_IN_STR_LO:  in_str_lo  <= cfg_data;
        REG_IN_STR_HI:  in_str_hi  <= cfg_data;
        REG_OUT_STR_LO: out_str_lo <= cfg_data;
        REG_OUT_STR_HI: out_str_hi <= cfg_data;
        REG_DIMS_LO:    dims_lo    <= cfg_data;
        REG_DIMS_HI:    dims_hi    <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
    end
    st[0].contig <= contiguous;
    st[0].pos    <= out_position;
    st[0].rest   <= out_position;
    st[0].rem    <= '0;
    st[0].quo    <= '0;
    st[0].src    <= '0;
    st[0].dst    <= '0;
  end

  for (genvar s = 0; s < NST; s++) begin : g_stage
    localparam int K = s / AXIS_ST;
    localparam int J = s % AXIS_ST;

    tpig_stage_t        nxt;
    logic [2:0]         ax;
    logic [FIELD_W-1:0] divisor;

    always_comb begin
      ax      = st[s].contig ? 3'(K) : 3'(n_axes - 3'(K) - 3'd1);
      divisor = st[s].contig ? pick_field(out_str_lo, out_str_hi, ax)
                             : pick_field(dims_lo, dims_hi, ax);
    end

    if (J < DIV_STEPS) begin : g_div
      always_comb begin
        logic [IDX_W:0] r;
        nxt = st[s];
        if (J == 0) begin
          nxt.rem = '0;
          nxt.quo = '0;
        end
        for (int b = 0; b < DIV_BITS; b++) begin
          if (IDX_W - 1 - (J * DIV_BITS + b) >= 0) begin
            r = {nxt.rem, nxt.rest[IDX_W - 1 - (J * DIV_BITS + b)]};
            if (r >= {1'b0, divisor}) begin
              r = r - {1'b0, divisor};
              nxt.quo[IDX_W - 1 - (J * DIV_BITS + b)] = 1'b1;
            end
            nxt.rem = r[IDX_W-1:0];
          end
        end
      end
    end else begin : g_mac
      logic [FIELD_W-1:0] sstride, ostride;
      logic [2:0]         sax;
      logic               active;
      logic [IDX_W-1:0]   q, rm, coef;
      logic [IDX_W+FIELD_W-1:0] sprod, dprod;

      always_comb begin
        active  = 3'(K) < n_axes;
        sax     = axis_order[ax*3 +: 3];
        sstride = pick_field(in_str_lo, in_str_hi, sax);
        ostride = pick_field(out_str_lo, out_str_hi, ax);
        // zero divisor: quotient zero, remainder is the dividend
        q     = (divisor == '0) ? '0 : st[s].quo;
        rm    = (divisor == '0) ? st[s].rest : st[s].rem;
        coef  = st[s].contig ? q : rm;
        sprod = coef * sstride;
        dprod = coef * ostride;
        nxt   = st[s];
        if (active) begin
          nxt.rest = st[s].contig ? rm : q;
          nxt.src  = st[s].src + sprod[IDX_W-1:0];
          if (!st[s].contig) begin
            nxt.dst = st[s].dst + dprod[IDX_W-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      st[s+1] <= nxt;
    end
  end

  assign done         = vld[NST];
  assign source_index = st[NST].src;
  assign dest_index   = st[NST].contig ? st[NST].pos : st[NST].dst;

endmodule

[rtl/tpig_checker.sv]
// ----------------------------------------------------------------------------
// tpig_checker
// port-level timing checks of the permute index generator
// ----------------------------------------------------------------------------
`include "tensor_permute_index_generator_core_macros.svh"

module tpig_checker
  import tpig_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic [IDX_W-1:0] out_position,
  input logic             contiguous,
  input logic             done,
  input logic [IDX_W-1:0] dest_index,
  input logic             cfg_ready
);

  `TPIG_ASSERT_LATER(a_beat_gives_result, clk, rst, start && !busy, LATENCY, done)
  `TPIG_ASSERT_NOW(a_result_has_beat, clk, rst, done, $past(start && !busy, LATENCY))
  `TPIG_ASSERT_LATER(a_contig_dest, clk, rst, start && !busy && contiguous, LATENCY, dest_index == $past(out_position, LATENCY))
  `TPIG_ASSERT_NOW(a_always_open, clk, rst, 1'b1, !busy && cfg_ready)

endmodule

bind tensor_permute_index_generator_core tpig_checker u_tpig_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .out_position (out_position),
  .contiguous   (contiguous),
  .done         (done),
  .dest_index   (dest_index),
  .cfg_ready    (cfg_ready)
);
